### hdl/ocr_pkg.sv
// Shared constants and codes for the orbit canonical representative block.
// No dependencies; imported by ocr_perm_mem, orbit_canonical_representative and tb_top.
package ocr_pkg;

    localparam int ENTRY_W  = 5;   // bits of one permutation entry (image site)
    localparam int WORD_W   = 32;  // occupation word width
    localparam int PERM_W   = 6;   // perm_number field width
    localparam int SITE_W   = 5;   // source_site / dest_site field width
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int SYM_CNT_W  = 7;
    localparam int SITE_CNT_W = 6;

    // tuser codes on the input stream
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYM_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SITE_COUNT = 2'd1;

    typedef logic [WORD_W-1:0] word_t;

endpackage

### hdl/orbit_canonical_representative.sv
// Top level of the orbit canonical representative block: stream ports,
// query sequencer, image and compare pipeline. Uses ocr_pkg and ocr_perm_mem.
//
// Usage:
//   s_* input stream, one word per item. s_tuser is the kind: load (0)
//   writes one permutation entry, query (1) asks for the smallest image
//   of an (up, down) word pair over all loaded symmetries.
//   m_* output stream, one word per query (loads give nothing).
//   cfg_* plain write port: symmetry_count (index 0), site_count (index 1).
//   Write configuration only while the block is idle.
// Timing:
//   A load leaves the block idle, so it is ready again for the next item.
//   With n = symmetry_count saturated to MAX_SYMMETRIES, a query reads
//   n permutation rows from the table, one row per cycle, then forms the
//   images, compares them, sees the pipe drained and loads the result
//   register. The table's single read port sets that rate. One item is
//   in work at a time.
// Reset:
//   rst_n clears control state and sets symmetry_count to 1 and
//   site_count to 32. The table is not cleared; rows must be loaded
//   before queries use them.
// Stall:
//   A finished result waits in the output register; the block keeps taking
//   items meanwhile. A second result waits in its final state until the
//   output register frees up.
module orbit_canonical_representative #(
    parameter int MAX_SITES      = 32,
    parameter int MAX_SYMMETRIES = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [5:0] perm_number, [10:6] source_site, [15:11] dest_site,
    // [47:16] up_word, [79:48] down_word
    input  logic [79:0]                       s_tdata,
    // [0] kind
    input  logic                              s_tuser,
    // output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [31:0] rep_up, [63:32] rep_down, [64] is_canonical, [71:65] zero
    output logic [71:0]                       m_tdata,
    // configuration
    input  logic                              cfg_we,
    input  logic [ocr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ocr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ocr_pkg::*;

    // Only the first 32 sites of a row can ever be used (word width).
    localparam int USED_SITES = (MAX_SITES < WORD_W) ? MAX_SITES : WORD_W;
    localparam int EW = (USED_SITES > 1) ? $clog2(USED_SITES) : 1;
    localparam int RW = (MAX_SYMMETRIES > 1) ? $clog2(MAX_SYMMETRIES) : 1;
    localparam int CW = $clog2(MAX_SYMMETRIES + 1);
    localparam int ROW_W = USED_SITES * ENTRY_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // input field unpack
    logic [PERM_W-1:0] perm_number;
    logic [SITE_W-1:0] source_site;
    logic [SITE_W-1:0] dest_site;
    word_t             up_word;
    word_t             down_word;

    assign perm_number = s_tdata[5:0];
    assign source_site = s_tdata[10:6];
    assign dest_site   = s_tdata[15:11];
    assign up_word     = s_tdata[47:16];
    assign down_word   = s_tdata[79:48];

    // configuration
    logic [SYM_CNT_W-1:0]  sym_count_reg;
    logic [SITE_CNT_W-1:0] site_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_count_reg  <= SYM_CNT_W'(1);
            site_count_reg <= SITE_CNT_W'(32);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_SYM_COUNT)
            begin
                sym_count_reg <= cfg_data;
            end
            else if (cfg_index == REG_SITE_COUNT)
            begin
                site_count_reg <= cfg_data[SITE_CNT_W-1:0];
            end
        end
    end

    // saturated counts
    logic [CW-1:0]         nsym_eff;
    logic [SITE_CNT_W-1:0] nsites_eff;

    always_comb
    begin
        if (int'(sym_count_reg) > MAX_SYMMETRIES)
            nsym_eff = CW'(MAX_SYMMETRIES);
        else
            nsym_eff = CW'(sym_count_reg);
        if (int'(site_count_reg) > USED_SITES)
            nsites_eff = SITE_CNT_W'(USED_SITES);
        else
            nsites_eff = site_count_reg;
    end

    // control state
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] rd_cnt_reg, rd_cnt_next;
    logic          rd_vld_reg, rd_vld_next;    // row data valid at memory output
    logic          img_vld_reg, img_vld_next;  // images valid
    logic          out_vld_reg, out_vld_next;

    // payload
    word_t q_up_reg, q_dn_reg;
    word_t best_up_reg, best_dn_reg;
    word_t img_up_reg, img_dn_reg;
    word_t rep_up_reg, rep_dn_reg;
    logic  canon_reg;

    logic in_acc;
    logic load_acc;
    logic query_acc;
    logic mem_we;
    logic issue;
    logic out_load;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign load_acc  = in_acc && (s_tuser == KIND_LOAD);
    assign query_acc = in_acc && (s_tuser == KIND_QUERY);
    // out-of-range loads are dropped
    assign mem_we    = load_acc && (int'(perm_number) < MAX_SYMMETRIES)
                       && (int'(source_site) < MAX_SITES);
    assign issue     = (state_reg == ST_RUN) && (rd_cnt_reg != nsym_eff);
    assign out_load  = (state_reg == ST_DONE) && (!out_vld_reg || m_tready);

    // Writes happen only in idle and reads only in run, so a row is never
    // read and written in the same cycle.
    logic [ROW_W-1:0] row_data;

    ocr_perm_mem #(
        .ROWS  (MAX_SYMMETRIES),
        .SITES (USED_SITES),
        .RW    (RW),
        .EW    (EW)
    ) u_mem (
        .clk      (clk),
        .we       (mem_we),
        .wr_row   (RW'(perm_number)),
        .wr_entry (source_site[EW-1:0]),
        .wr_data  (dest_site),
        .re       (issue),
        .rd_row   (rd_cnt_reg[RW-1:0]),
        .rd_data  (row_data)
    );

    // image formation: bit j goes to the site in entry j
    word_t img_up_next, img_dn_next;

    always_comb
    begin
        img_up_next = '0;
        img_dn_next = '0;
        for (int j = 0; j < USED_SITES; j++)
        begin
            if (j < int'(nsites_eff))
            begin
                if (q_up_reg[j])
                    img_up_next[row_data[j*ENTRY_W +: ENTRY_W]] = 1'b1;
                if (q_dn_reg[j])
                    img_dn_next[row_data[j*ENTRY_W +: ENTRY_W]] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            img_up_reg <= img_up_next;
            img_dn_reg <= img_dn_next;
        end
    end

    // running minimum, up word first
    logic better;
    assign better = (img_up_reg < best_up_reg) ||
                    ((img_up_reg == best_up_reg) && (img_dn_reg < best_dn_reg));

    always_ff @(posedge clk)
    begin
        if (query_acc)
        begin
            q_up_reg    <= up_word;
            q_dn_reg    <= down_word;
            best_up_reg <= up_word;
            best_dn_reg <= down_word;
        end
        else if (img_vld_reg && better)
        begin
            best_up_reg <= img_up_reg;
            best_dn_reg <= img_dn_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        rd_cnt_next  = rd_cnt_reg;
        rd_vld_next  = issue;
        img_vld_next = rd_vld_reg;
        out_vld_next = out_vld_reg;
        if (m_tvalid && m_tready)
            out_vld_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_acc)
                begin
                    state_next  = ST_RUN;
                    rd_cnt_next = '0;
                end
            end
            ST_RUN:
            begin
                if (issue)
                    rd_cnt_next = rd_cnt_reg + CW'(1);
                else if (!rd_vld_reg && !img_vld_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next   = ST_IDLE;
                    out_vld_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_cnt_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            img_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_cnt_reg  <= rd_cnt_next;
            rd_vld_reg  <= rd_vld_next;
            img_vld_reg <= img_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rep_up_reg <= best_up_reg;
            rep_dn_reg <= best_dn_reg;
            canon_reg  <= (best_up_reg == q_up_reg) && (best_dn_reg == q_dn_reg);
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, canon_reg, rep_dn_reg, rep_up_reg};

    // checks
    a_we_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_IDLE))
        else $error("table write outside idle");

    a_pipe_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_vld_reg || img_vld_reg) |-> (state_reg == ST_RUN))
        else $error("pipeline busy outside run");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (rd_cnt_reg <= nsym_eff))
        else $error("row counter past symmetry count");

    a_best_le_query: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !((q_up_reg < best_up_reg) ||
            ((q_up_reg == best_up_reg) && (q_dn_reg < best_dn_reg))))
        else $error("best pair larger than query");

    a_done_one_cycle_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (m_tvalid && (state_reg == ST_IDLE)))
        else $error("result not presented after done");

endmodule

### hdl/ocr_perm_mem.sv
// Permutation table: one row per symmetry, written one entry at a time,
// read one whole row per cycle with registered read data. Uses ocr_pkg.
module ocr_perm_mem #(
    parameter int ROWS  = 64,
    parameter int SITES = 32,
    parameter int RW    = 6,
    parameter int EW    = 5
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [RW-1:0]                     wr_row,
    input  logic [EW-1:0]                     wr_entry,
    input  logic [ocr_pkg::ENTRY_W-1:0]       wr_data,
    input  logic                              re,
    input  logic [RW-1:0]                     rd_row,
    output logic [SITES*ocr_pkg::ENTRY_W-1:0] rd_data
);
    import ocr_pkg::*;

    // one row per address, entry j in bits [j*ENTRY_W +: ENTRY_W]
    logic [SITES*ENTRY_W-1:0] mem [ROWS];
    logic [SITES*ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_row][wr_entry*ENTRY_W +: ENTRY_W] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_data_reg <= mem[rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for orbit_canonical_representative: loads permutation rows, sends queries,
// checks each representative word against a built-in orbit-minimum predictor.
// Depends on ocr_pkg and the block's RTL only.
module tb_top;

    import ocr_pkg::*;

    localparam int MAX_SITES      = 32;
    localparam int MAX_SYMMETRIES = 64;
    localparam int PHASE_ITEMS    = 100;
    // table fill: rows below FULL_ROWS get every site, the rest the low sites only
    localparam int FULL_ROWS      = 16;
    localparam int NARROW_SITES   = 8;

    // register indexes past the end of the map; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // settings for the random phases, extremes and saturation cases included
    localparam logic [CFG_DATA_W-1:0] PHASE_SYM [8] =
        '{7'd1, 7'd64, 7'd7, 7'd127, 7'd0, 7'd33, 7'd12, 7'd16};
    localparam logic [CFG_DATA_W-1:0] PHASE_SITE [8] =
        '{7'd32, 7'd8, 7'd16, 7'd7, 7'd20, 7'd1, 7'd0, 7'd33};

    typedef struct {
        word_t up;
        word_t down;
        logic  canonical;
    } orbit_rep_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [79:0]           s_tdata = '0;
    logic                  s_tuser = KIND_LOAD;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [71:0]           m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor state: its own copy of the table and of both registers
    logic [ENTRY_W-1:0]    site_map [MAX_SYMMETRIES][MAX_SITES];
    logic [SYM_CNT_W-1:0]  sym_count_reg = 7'd1;
    logic [SITE_CNT_W-1:0] site_count_reg = 6'd32;

    orbit_rep_t            pending_reps [$];
    orbit_rep_t            last_rep;
    bit                    have_rep = 1'b0;
    int                    mismatch_count = 0;
    int                    result_count = 0;
    bit                    tx_steady = 1'b0;   // sender never idles
    bit                    rx_steady = 1'b0;   // receiver never stalls

    orbit_canonical_representative #(
        .MAX_SITES      (MAX_SITES),
        .MAX_SYMMETRIES (MAX_SYMMETRIES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // bit j of w moves to the site held in entry j of the row
    function automatic word_t permute_word(input int row, input int nsites, input word_t w);
        word_t img;
        img = '0;
        for (int j = 0; j < nsites; j++)
        begin
            if (w[j])
                img[site_map[row][j]] = 1'b1;
        end
        return img;
    endfunction

    function automatic orbit_rep_t orbit_minimum(input word_t up, input word_t down);
        orbit_rep_t best;
        int         nsym;
        int         nsites;
        word_t      img_up;
        word_t      img_down;
        nsym   = (sym_count_reg > MAX_SYMMETRIES) ? MAX_SYMMETRIES : int'(sym_count_reg);
        nsites = (site_count_reg > MAX_SITES) ? MAX_SITES : int'(site_count_reg);
        if (nsites > WORD_W)
            nsites = WORD_W;
        best.up   = up;
        best.down = down;
        for (int i = 0; i < nsym; i++)
        begin
            img_up   = permute_word(i, nsites, up);
            img_down = permute_word(i, nsites, down);
            if (img_up < best.up || (img_up == best.up && img_down < best.down))
            begin
                best.up   = img_up;
                best.down = img_down;
            end
        end
        best.canonical = (best.up == up && best.down == down);
        return best;
    endfunction

    // a setting reads loaded entries only: few rows, or few sites per row
    function automatic bit reads_loaded(input logic [CFG_DATA_W-1:0] nsym,
                                        input logic [CFG_DATA_W-1:0] nsites);
        return (int'(nsym) <= FULL_ROWS) || (int'(nsites) <= NARROW_SITES);
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // tdata: perm_number, source_site, dest_site, up_word, down_word from bit 0 up
    function automatic logic [79:0] load_word(input logic [PERM_W-1:0] row,
                                              input logic [SITE_W-1:0] src,
                                              input logic [SITE_W-1:0] dst);
        word_t fill_up;
        word_t fill_down;
        fill_up   = $urandom();
        fill_down = $urandom();
        return {fill_down, fill_up, dst, src, row};
    endfunction

    function automatic logic [79:0] query_word(input word_t up, input word_t down);
        logic [PERM_W-1:0] row;
        logic [SITE_W-1:0] src;
        logic [SITE_W-1:0] dst;
        row = PERM_W'($urandom_range(0, 63));
        src = SITE_W'($urandom_range(0, 31));
        dst = SITE_W'($urandom_range(0, 31));
        return {down, up, dst, src, row};
    endfunction

    function automatic word_t random_word();
        word_t w;
        case ($urandom_range(0, 5))
            0, 1: w = $urandom();
            2:    w = (32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31));
            3:    w = ~((32'd1 << $urandom_range(0, 31)) | (32'd1 << $urandom_range(0, 31)));
            4:    w = $urandom() & $urandom() & $urandom();
            default: w = $urandom_range(0, 1) ? '0 : '1;
        endcase
        return w;
    endfunction

    function automatic void shuffle(ref int a [MAX_SITES]);
        int k;
        int t;
        for (int i = MAX_SITES - 1; i > 0; i--)
        begin
            k    = $urandom_range(0, i);
            t    = a[i];
            a[i] = a[k];
            a[k] = t;
        end
    endfunction

    // predictor side of an accepted word
    task automatic absorb_word(input logic kind, input logic [79:0] payload);
        logic [PERM_W-1:0] row;
        logic [SITE_W-1:0] src;
        row = payload[5:0];
        src = payload[10:6];
        if (kind == KIND_LOAD)
        begin
            if (row < MAX_SYMMETRIES && src < MAX_SITES)
                site_map[row][src] = payload[15:11];
        end
        else
        begin
            last_rep = orbit_minimum(payload[47:16], payload[79:48]);
            have_rep = 1'b1;
            pending_reps = {pending_reps, last_rep};
        end
    endtask

    // one word on the input stream; returns at the accepting edge
    task automatic send_word(input logic kind, input logic [79:0] payload);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 15);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser  = kind;
        s_tdata  = payload;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        absorb_word(kind, payload);
    endtask

    task automatic send_query(input word_t up, input word_t down);
        send_word(KIND_QUERY, query_word(up, down));
    endtask

    // entries below count of a row, taken from a random permutation, in random order
    task automatic load_row(input int row, input int count);
        int img [MAX_SITES];
        int ord [MAX_SITES];
        for (int i = 0; i < MAX_SITES; i++)
        begin
            img[i] = i;
            ord[i] = i;
        end
        shuffle(img);
        shuffle(ord);
        for (int i = 0; i < MAX_SITES; i++)
        begin
            if (ord[i] < count)
                send_word(KIND_LOAD, load_word(PERM_W'(row), SITE_W'(ord[i]),
                                               SITE_W'(img[ord[i]])));
        end
    endtask

    task automatic park_stream();
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // stream quiet, every result back, trailing load retired
    task automatic settle_block();
        park_stream();
        while (pending_reps.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        settle_block();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
        if (idx == REG_SYM_COUNT)
            sym_count_reg = val[SYM_CNT_W-1:0];
        else if (idx == REG_SITE_COUNT)
            site_count_reg = val[SITE_CNT_W-1:0];
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] nsym,
                             input logic [CFG_DATA_W-1:0] nsites);
        write_register(REG_SYM_COUNT, nsym);
        write_register(REG_SITE_COUNT, nsites);
    endtask

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        mismatch_count++;
        $display("MISMATCH result %0d %s: got %h want %h", result_count, what, got, want);
    endtask

    task automatic check_result(input logic [71:0] beat);
        orbit_rep_t want;
        result_count++;
        if (pending_reps.size() == 0)
        begin
            flag_mismatch("unexpected word", beat[31:0], '0);
            return;
        end
        want = pending_reps.pop_front();
        if (beat[31:0] !== want.up)
            flag_mismatch("rep_up", beat[31:0], want.up);
        if (beat[63:32] !== want.down)
            flag_mismatch("rep_down", beat[63:32], want.down);
        if (beat[64] !== want.canonical)
            flag_mismatch("is_canonical", 32'(beat[64]), 32'(want.canonical));
        if (beat[71:65] !== '0)
            flag_mismatch("pad bits", 32'(beat[71:65]), '0);
    endtask

    initial
    begin : result_checker
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = rx_steady ? 0 : $urandom_range(0, 15);
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            check_result(m_tdata);
        end
    end

    // ---------------------------------------------------------------- tests

    // every entry a query setting can reach is loaded first; loads give no word
    task automatic test_table_fill();
        for (int row = 0; row < MAX_SYMMETRIES; row++)
            load_row(row, (row < FULL_ROWS) ? MAX_SITES : NARROW_SITES);
        settle_block();
    endtask

    // reset values: one symmetry over all 32 sites
    task automatic test_default_config();
        send_query('0, '0);
        send_query('1, '1);
        send_query(32'h0000_0001, '0);
        send_query(32'h8000_0000, 32'h0000_0001);
        send_query($urandom(), $urandom());
    endtask

    // no symmetries: the query comes back as is, always canonical
    task automatic test_zero_symmetries();
        configure(7'd0, 7'd32);
        send_query('1, '0);
        send_query(32'h1234_5678, 32'hDEAD_BEEF);
    endtask

    // counts past the limits saturate
    task automatic test_saturation();
        configure(7'd127, 7'd8);
        send_query($urandom(), $urandom());
        send_query(random_word(), random_word());
        configure(7'd16, 7'h7F);
        send_query($urandom(), $urandom());
        configure(7'd65, 7'd5);
        send_query($urandom(), $urandom());
        configure(7'd3, 7'd33);
        send_query(random_word(), '0);
    endtask

    // zero sites: every image collapses to the empty pair
    task automatic test_zero_sites();
        configure(7'd4, 7'd0);
        send_query('0, '0);
        send_query('0, 32'h0000_0005);
        send_query(32'h0000_0007, '0);
    endtask

    // bits above the site count stay in the query, drop out of images
    task automatic test_high_bits();
        configure(7'd64, 7'd4);
        send_query(32'hFFFF_FFF0, 32'hF000_0003);
        send_query(32'h8000_000C, '0);
        send_query(32'h0000_000F, 32'h0000_000F);
    endtask

    // writes to unmapped indexes leave both registers alone
    task automatic test_unused_index();
        configure(7'd3, 7'd10);
        write_register(REG_SPARE_A, 7'd0);
        write_register(REG_SPARE_B, 7'h7F);
        send_query($urandom(), $urandom());
        send_query(random_word(), random_word());
    endtask

    // single species, and ties on the up word settled by the down word
    task automatic test_single_species();
        configure(7'd16, 7'd32);
        send_query($urandom(), '0);
        send_query('0, $urandom());
        send_query('1, $urandom());
    endtask

    task automatic test_random();
        int n;
        int pick;
        logic [CFG_DATA_W-1:0] nsym;
        logic [CFG_DATA_W-1:0] nsites;
        word_t down;
        for (int phase = 0; phase < 10; phase++)
        begin
            if (phase < 8)
            begin
                nsym   = PHASE_SYM[phase];
                nsites = PHASE_SITE[phase];
            end
            else
            begin
                nsym   = CFG_DATA_W'($urandom_range(0, 127));
                nsites = CFG_DATA_W'($urandom_range(0, 127));
                if (!reads_loaded(nsym, nsites))
                    nsites = CFG_DATA_W'($urandom_range(0, NARROW_SITES));
            end
            // configuring drains the block: the sender waits for every word
            configure(nsym, nsites);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                begin
                    load_row($urandom_range(0, MAX_SYMMETRIES - 1), MAX_SITES);
                    n += MAX_SITES;
                end
                else if (pick < 18)
                begin
                    send_word(KIND_LOAD, load_word(PERM_W'($urandom_range(0, 63)),
                                                   SITE_W'($urandom_range(0, 31)),
                                                   SITE_W'($urandom_range(0, 31))));
                    n++;
                end
                else if (pick < 33 && have_rep)
                begin
                    // a representative sent back in should mostly be canonical
                    send_query(last_rep.up, last_rep.down);
                    n++;
                end
                else
                begin
                    down = ($urandom_range(0, 3) == 0) ? '0 : random_word();
                    send_query(random_word(), down);
                    n++;
                end
                if ($urandom_range(0, 99) == 0)
                    settle_block();
            end
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin : main_sequence
        int waited;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_table_fill();
        test_default_config();
        test_zero_symmetries();
        test_saturation();
        test_zero_sites();
        test_high_bits();
        test_unused_index();
        test_single_species();
        test_random();

        park_stream();
        waited = 0;
        while (pending_reps.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_reps.size() != 0)
            flag_mismatch("words never delivered", pending_reps.size(), '0);
        repeat (MAX_SYMMETRIES + 16) @(posedge clk);

        if (mismatch_count == 0)
            $display("orbit_canonical_representative verification clean");
        else
            $display("orbit_canonical_representative verification failed");
        $finish;
    end

    // hang guard, well past the slowest legal run
    initial
    begin : watchdog
        #20_000_000;
        $display("orbit_canonical_representative verification failed");
        $finish;
    end

endmodule
